// ===== src/ffha_pkg.sv =====
// Shared types, constants and codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int ADDR_W   = 12;
  localparam int REQ_W    = 12;
  localparam int LIMIT_W  = 13;
  localparam int SIZE_W   = 13;
  localparam int STATUS_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED   = 2'd0,
    ST_EXTENDED = 2'd1,
    ST_NOMEM    = 2'd2
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_EXTEND,
    S_FREE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic take;
    logic step;
    logic extend;
    logic free_mark;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_free;
    logic walk_more;
    logic hit;
    logic zero_size;
    logic slot_free;
  } dp_stat_t;

endpackage

// ===== src/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ffha_ctrl.sv =====
// Controller state machine for the heap allocator.
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffha_pkg::dp_stat_t stat,
  output ffha_pkg::ctl_cmd_t cmd
);
  import ffha_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_free ? S_FREE : S_WALK;
        end
      end
      S_WALK: begin
        state_next = stat.walk_more ? S_CHECK : S_EXTEND;
      end
      S_CHECK: begin
        if (stat.hit) begin
          state_next = S_RESULT;
        end else if (stat.zero_size) begin
          state_next = S_EXTEND;
        end else begin
          state_next = S_WALK;
        end
      end
      S_EXTEND: state_next = S_RESULT;
      S_FREE:   state_next = S_RESULT;
      S_RESULT: begin
        if (stat.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_WALK: begin
      end
      S_CHECK: begin
        cmd.take = stat.hit;
        cmd.step = !stat.hit && !stat.zero_size;
      end
      S_EXTEND: cmd.extend    = 1'b1;
      S_FREE:   cmd.free_mark = 1'b1;
      S_RESULT: cmd.emit      = stat.slot_free;
      default: begin
      end
    endcase
  end

endmodule

// ===== src/ffha_dp.sv =====
// Datapath: header stores, walk pointer, break, limit and output register.
module ffha_dp #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffha_pkg::ctl_cmd_t            cmd,
  output ffha_pkg::dp_stat_t            stat,
  input  logic                          command,
  input  logic [ffha_pkg::REQ_W-1:0]    request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]   block_address,
  input  logic                          cfg_valid,
  input  logic [ffha_pkg::LIMIT_W-1:0]  cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]   user_address,
  output logic [ffha_pkg::STATUS_W-1:0] status
);
  import ffha_pkg::*;

  localparam int MW = $clog2(HEAP_BYTES);
  localparam int BW = MW + 1;
  localparam int CW = ((BW > SIZE_W) ? BW : SIZE_W) + 1;

  logic [BW-1:0]     break_offset;
  logic [BW-1:0]     break_offset_next;
  logic [CW-1:0]     cur;
  logic [SIZE_W-1:0] need;
  logic [ADDR_W-1:0] free_addr;
  logic [LIMIT_W-1:0] heap_limit;
  logic [ADDR_W-1:0] res_addr;
  result_t           res_status;

  logic [CW-1:0]     lim;
  logic [CW-1:0]     ext_end;
  logic              nomem;
  logic [CW-1:0]     free_off;
  logic              free_ok;
  logic              rd_free;
  logic [SIZE_W-1:0] rd_size;

  logic              fr_we;
  logic [MW-1:0]     fr_waddr;
  logic              sz_we;

  always_comb begin
    lim = (CW'(heap_limit) > CW'(HEAP_BYTES)) ? CW'(HEAP_BYTES) : CW'(heap_limit);
    ext_end  = CW'(break_offset) + CW'(need);
    nomem    = ext_end > lim;
    break_offset_next = BW'(ext_end);
    free_off = CW'(free_addr) - CW'(HEADER_BYTES);
    free_ok  = (CW'(free_addr) >= CW'(HEADER_BYTES)) && (free_off < CW'(HEAP_BYTES));
  end

  always_comb begin
    stat.in_free   = (command == CMD_FREE);
    stat.walk_more = cur < CW'(break_offset);
    stat.hit       = rd_free && (rd_size >= need);
    stat.zero_size = (rd_size == '0);
    stat.slot_free = !out_valid || !out_stall;
  end

  always_comb begin
    fr_we    = cmd.take || (cmd.extend && !nomem) || (cmd.free_mark && free_ok);
    fr_waddr = free_off[MW-1:0];
    if (cmd.take) begin
      fr_waddr = cur[MW-1:0];
    end else if (cmd.extend) begin
      fr_waddr = break_offset[MW-1:0];
    end
    sz_we = cmd.extend && !nomem;
  end

  ffha_ram #(.WIDTH(1), .DEPTH(HEAP_BYTES)) u_free_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (cmd.free_mark),
    .raddr (cur[MW-1:0]),
    .rdata (rd_free)
  );

  ffha_ram #(.WIDTH(SIZE_W), .DEPTH(HEAP_BYTES)) u_size_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (break_offset[MW-1:0]),
    .wdata (need),
    .raddr (cur[MW-1:0]),
    .rdata (rd_size)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      break_offset <= '0;
      heap_limit   <= LIMIT_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        heap_limit <= cfg_data;
      end
      if (cmd.extend && !nomem) begin
        break_offset <= break_offset_next;
      end
      out_valid <= cmd.emit || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur       <= '0;
      need      <= SIZE_W'(request_bytes) + SIZE_W'(HEADER_BYTES);
      free_addr <= block_address;
    end else if (cmd.step) begin
      cur <= cur + CW'(rd_size);
    end
    if (cmd.take) begin
      res_addr   <= ADDR_W'(cur + CW'(HEADER_BYTES));
      res_status <= ST_REUSED;
    end else if (cmd.extend) begin
      if (nomem) begin
        res_addr   <= '0;
        res_status <= ST_NOMEM;
      end else begin
        res_addr   <= ADDR_W'(CW'(break_offset) + CW'(HEADER_BYTES));
        res_status <= ST_EXTENDED;
      end
    end else if (cmd.free_mark) begin
      res_addr   <= '0;
      res_status <= ST_REUSED;
    end
    if (cmd.emit) begin
      user_address <= res_addr;
      status       <= res_status;
    end
  end

endmodule

// ===== src/first_fit_heap_allocator_top.sv =====
// Free: S_FREE, S_RESULT. Allocate: walk S_WALK/S_CHECK, then S_EXTEND or S_RESULT.
// Throughput: one item at a time; the next beat is taken once the result is
// handed to the output register, and the walk reads the headers one at a time
// through the single read port of the header RAMs.
// Reset: clears the break, control state and output valid, sets heap_limit to
// 4096; header RAM contents are not initialized.
module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [ffha_pkg::REQ_W-1:0]    request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]   block_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]   user_address,
  output logic [ffha_pkg::STATUS_W-1:0] status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffha_pkg::LIMIT_W-1:0]  cfg_data
);
  import ffha_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .command       (command),
    .request_bytes (request_bytes),
    .block_address (block_address),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .user_address  (user_address),
    .status        (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted beat");

  a_emit_fills_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

  a_nomem_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOMEM |-> user_address == '0)
    else $error("out of memory result carries an address");

endmodule
